[hw/rtl/cjr_pkg.sv]
// shared command types and action codes for the contact jacobian row unit
package cjr_pkg;

   // action codes of a request
   localparam logic [1:0] ACT_CONTACT = 2'd0;
   localparam logic [1:0] ACT_BODY0   = 2'd1;
   localparam logic [1:0] ACT_BODY1   = 2'd2;

   // controller to datapath command
   typedef struct packed {
      logic       load_in;
      logic       load_contact;
      logic       calc_d;
      logic [4:0] step;
      logic       out_load;
   } cjr_cmd_type;

endpackage

[hw/rtl/cjr_if.sv]
// valid/ready channel interface carrying a generic payload
interface cjr_if #(parameter int PAYLOAD_WIDTH = 8);
   logic                     valid;
   logic                     ready;
   logic [PAYLOAD_WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/contact_jacobian_row_rotated_frame_unit.sv]
// top level of the contact jacobian row unit
// channel | dir | payload
// req     | in  | action, vec_x/y/z, aux_x/y/z, quat_w
// rsp     | out | body_index, lin_x/y/z, ang_x/y/z
// a contact request gives no response
// a body request runs 27 sequencer steps on one shared product pair; the response register is
// loaded at the last step, and no request is accepted until the sequencer is idle again
// reset clears the contact to zero and the sequencer to idle
// a held response stalls the next body request at its last step until it is taken
module contact_jacobian_row_rotated_frame_unit
   import cjr_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   cjr_if.sink   req,
   cjr_if.source rsp
);
   localparam int W = DATA_WIDTH;

   cjr_cmd_type         cmd;
   logic signed [W-1:0] vec [3];
   logic signed [W-1:0] aux [3];
   logic signed [W-1:0] lin [3];
   logic signed [W-1:0] ang [3];
   logic                bidx;
   logic [1:0]          act;

   // request payload: action in the top bits, then vec, aux, quat_w
   assign act    = req.data[7*W+1:7*W];
   assign vec[0] = req.data[7*W-1:6*W];
   assign vec[1] = req.data[6*W-1:5*W];
   assign vec[2] = req.data[5*W-1:4*W];
   assign aux[0] = req.data[4*W-1:3*W];
   assign aux[1] = req.data[3*W-1:2*W];
   assign aux[2] = req.data[2*W-1:W];

   cjr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_action(act),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd)
   );

   cjr_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_action(act),
      .req_vec(vec), .req_aux(aux), .req_quat_w(req.data[W-1:0]),
      .rsp_body_index(bidx), .rsp_lin(lin), .rsp_ang(ang)
   );

   // response payload: body_index, lin, ang
   assign rsp.data = {bidx, lin[0], lin[1], lin[2], ang[0], ang[1], ang[2]};
endmodule

[hw/rtl/cjr_ctrl.sv]
// sequencer for one body request: steps through the shared multiplier schedule
module cjr_ctrl
   import cjr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_action,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cjr_cmd_type cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;

   localparam logic [4:0] LAST_STEP = 5'd26;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       out_ff, out_in;
   logic       acc;
   logic       fin;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign fin       = (state_ff == ST_RUN) && (step_ff == LAST_STEP) && (!out_ff || rsp_ready);
   assign rsp_valid = out_ff;

   // next state logic
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      out_in   = out_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            step_in = 5'd0;
            if (acc && (req_action == ACT_BODY0 || req_action == ACT_BODY1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff != LAST_STEP) begin
               step_in = step_ff + 5'd1;
            end else if (fin) begin
               state_in = ST_IDLE;
               out_in   = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command to the datapath
   always_comb begin
      cmd.load_in      = acc;
      cmd.load_contact = acc && (req_action == ACT_CONTACT);
      cmd.calc_d       = (state_ff == ST_RUN) && (step_ff == 5'd0);
      cmd.step         = (state_ff == ST_RUN) ? step_ff : 5'd31;
      cmd.out_load     = fin;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 5'd0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         out_ff   <= out_in;
      end
   end
endmodule

[hw/rtl/cjr_datapath.sv]
// datapath: a shared pair of saturating fixed-point multipliers, adders, operand registers
module cjr_datapath
   import cjr_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cjr_cmd_type                  cmd,
   input  logic [1:0]                   req_action,
   input  logic signed [DATA_WIDTH-1:0] req_vec [3],
   input  logic signed [DATA_WIDTH-1:0] req_aux [3],
   input  logic signed [DATA_WIDTH-1:0] req_quat_w,
   output logic                         rsp_body_index,
   output logic signed [DATA_WIDTH-1:0] rsp_lin [3],
   output logic signed [DATA_WIDTH-1:0] rsp_ang [3]
);
   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * DATA_WIDTH;
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
      if (v > $signed({{3{1'b0}}, {(W-1){1'b1}}})) return VMAX;
      if (v < $signed({{3{1'b1}}, {(W-1){1'b0}}})) return VMIN;
      return v[W-1:0];
   endfunction

   // contact state
   logic signed [W-1:0] nrm_ff [3];
   logic signed [W-1:0] pnt_ff [3];
   // body request operands
   logic signed [W-1:0] g_ff [3];
   logic signed [W-1:0] u_ff [3];
   logic signed [W-1:0] w_ff;
   logic                neg_ff;
   // work registers
   logic signed [W-1:0] d_ff [3];
   logic signed [W-1:0] s_ff;
   logic signed [W-1:0] acc_ff;
   logic signed [W-1:0] ang_ff [3];
   logic signed [W-1:0] sq_ff [3];
   logic signed [W-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [W-1:0] m_ff [3][3];
   logic signed [W-1:0] ex_ff, ey_ff, dot_ff;
   logic [1:0]          jc;
   logic [2:0]          ph;
   logic signed [W-1:0] dbl_a, dbl_b;

   // multiplier operands and products
   logic signed [W-1:0]  cx, cy, cz;
   logic signed [W-1:0]  pa1, pb1, pa2, pb2;
   logic signed [PW-1:0] q1f, q2f, q1s, q2s;
   logic signed [W-1:0]  q1, q2;

   assign dbl_a = sat_w({{2{xy_ff[W-1]}}, xy_ff} + {{2{xy_ff[W-1]}}, xy_ff});
   assign dbl_b = sat_w({{2{wz_ff[W-1]}}, wz_ff} + {{2{wz_ff[W-1]}}, wz_ff});

   function automatic logic signed [W-1:0] dbl(input logic signed [W-1:0] a);
      return sat_w({{2{a[W-1]}}, a} + {{2{a[W-1]}}, a});
   endfunction
   function automatic logic signed [W-1:0] add(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
      return sat_w({{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
   endfunction
   function automatic logic signed [W-1:0] sub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
      return sat_w({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b});
   endfunction
   function automatic logic signed [W-1:0] neg(input logic signed [W-1:0] a);
      return (a == VMIN) ? VMAX : -a;
   endfunction

   // cross/dot schedule: steps 11..25, five steps per column
   always_comb begin
      jc = 2'd0;
      ph = 3'd0;
      if (cmd.step >= 5'd21 && cmd.step <= 5'd25) begin
         jc = 2'd2;
         ph = 3'(cmd.step - 5'd21);
      end else if (cmd.step >= 5'd16 && cmd.step <= 5'd20) begin
         jc = 2'd1;
         ph = 3'(cmd.step - 5'd16);
      end else if (cmd.step >= 5'd11 && cmd.step <= 5'd15) begin
         ph = 3'(cmd.step - 5'd11);
      end
   end

   assign cx = m_ff[0][jc];
   assign cy = m_ff[1][jc];
   assign cz = m_ff[2][jc];

   // operand schedule: steps 0..9 quaternion products on the first multiplier,
   // steps 11..25 cross and dot products on both
   always_comb begin
      pa1 = w_ff; pb1 = w_ff; pa2 = d_ff[2]; pb2 = cy;
      if (cmd.step >= 5'd11 && cmd.step <= 5'd25) begin
         case (ph)
            3'd0: begin pa1 = d_ff[1]; pb1 = cz; pa2 = d_ff[2]; pb2 = cy; end
            3'd1: begin pa1 = d_ff[2]; pb1 = cx; pa2 = d_ff[0]; pb2 = cz; end
            3'd2: begin pa1 = d_ff[0]; pb1 = cy; pa2 = d_ff[1]; pb2 = cx; end
            3'd3: begin pa1 = nrm_ff[0]; pb1 = ex_ff; pa2 = nrm_ff[1]; pb2 = ey_ff; end
            3'd4: begin pa1 = nrm_ff[2]; pb1 = acc_ff; pa2 = nrm_ff[2]; pb2 = acc_ff; end
            default: ;
         endcase
      end else begin
         case (cmd.step)
            5'd1:  begin pa1 = u_ff[0]; pb1 = u_ff[0]; end
            5'd2:  begin pa1 = u_ff[1]; pb1 = u_ff[1]; end
            5'd3:  begin pa1 = u_ff[2]; pb1 = u_ff[2]; end
            5'd4:  begin pa1 = u_ff[0]; pb1 = u_ff[1]; end
            5'd5:  begin pa1 = w_ff;    pb1 = u_ff[2]; end
            5'd6:  begin pa1 = u_ff[0]; pb1 = u_ff[2]; end
            5'd7:  begin pa1 = w_ff;    pb1 = u_ff[1]; end
            5'd8:  begin pa1 = u_ff[1]; pb1 = u_ff[2]; end
            5'd9:  begin pa1 = w_ff;    pb1 = u_ff[0]; end
            default: ;
         endcase
      end
   end

   // products: floor shift, saturate
   assign q1f = PW'(pa1) * PW'(pb1);
   assign q2f = PW'(pa2) * PW'(pb2);
   assign q1s = q1f >>> FRAC_BITS;
   assign q2s = q2f >>> FRAC_BITS;
   always_comb begin
      if (q1s > PW'(VMAX)) q1 = VMAX;
      else if (q1s < PW'(VMIN)) q1 = VMIN;
      else q1 = q1s[W-1:0];
      if (q2s > PW'(VMAX)) q2 = VMAX;
      else if (q2s < PW'(VMIN)) q2 = VMIN;
      else q2 = q2s[W-1:0];
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            nrm_ff[k] <= '0;
            pnt_ff[k] <= '0;
         end
      end else if (cmd.load_contact) begin
         for (int k = 0; k < 3; k++) begin
            nrm_ff[k] <= req_vec[k];
            pnt_ff[k] <= req_aux[k];
         end
      end
      if (cmd.load_in) begin
         for (int k = 0; k < 3; k++) begin
            g_ff[k] <= req_vec[k];
            u_ff[k] <= req_aux[k];
         end
         w_ff   <= req_quat_w;
         neg_ff <= (req_action == ACT_BODY1);
      end
      if (cmd.calc_d) begin
         for (int k = 0; k < 3; k++) d_ff[k] <= sub(g_ff[k], pnt_ff[k]);
      end
      // phase one: products of quaternion terms, then the rotation matrix from them
      case (cmd.step)
         5'd0: s_ff     <= q1;
         5'd1: sq_ff[0] <= q1;
         5'd2: sq_ff[1] <= q1;
         5'd3: sq_ff[2] <= q1;
         5'd4: xy_ff    <= q1;
         5'd5: wz_ff    <= q1;
         5'd6: xz_ff    <= q1;
         5'd7: wy_ff    <= q1;
         5'd8: yz_ff    <= q1;
         5'd9: wx_ff    <= q1;
         5'd10: begin
            m_ff[0][0] <= add(sub(s_ff, add(add(sq_ff[0], sq_ff[1]), sq_ff[2])), dbl(sq_ff[0]));
            m_ff[1][1] <= add(sub(s_ff, add(add(sq_ff[0], sq_ff[1]), sq_ff[2])), dbl(sq_ff[1]));
            m_ff[2][2] <= add(sub(s_ff, add(add(sq_ff[0], sq_ff[1]), sq_ff[2])), dbl(sq_ff[2]));
            m_ff[0][1] <= sub(dbl_a, dbl_b);
            m_ff[0][2] <= add(dbl(xz_ff), dbl(wy_ff));
            m_ff[1][0] <= add(dbl_a, dbl_b);
            m_ff[1][2] <= sub(dbl(yz_ff), dbl(wx_ff));
            m_ff[2][0] <= sub(dbl(xz_ff), dbl(wy_ff));
            m_ff[2][1] <= add(dbl(yz_ff), dbl(wx_ff));
         end
         default: ;
      endcase
      // phase two: cross product then dot with the normal
      if (cmd.step >= 5'd11 && cmd.step <= 5'd25) begin
         case (ph)
            3'd0: ex_ff      <= sub(q1, q2);
            3'd1: ey_ff      <= sub(q1, q2);
            3'd2: acc_ff     <= sub(q1, q2);
            3'd3: dot_ff     <= add(q1, q2);
            3'd4: ang_ff[jc] <= add(dot_ff, q1);
            default: ;
         endcase
      end
      // result register
      if (cmd.out_load) begin
         rsp_body_index <= neg_ff;
         for (int k = 0; k < 3; k++) begin
            rsp_lin[k] <= neg_ff ? neg(nrm_ff[k]) : nrm_ff[k];
            rsp_ang[k] <= neg_ff ? neg(ang_ff[k]) : ang_ff[k];
         end
      end
   end
endmodule

[tb/cjr_row_checker.sv]
// checker for the contact jacobian row unit: predicts rows and compares responses
`timescale 1ns / 1ps
module cjr_row_checker
   import cjr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cjr_if       req,
   cjr_if       rsp,
   output int   fail_count,
   output int   rows_pending
);

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   typedef struct packed {
      logic              body_index;
      logic signed [31:0] lin_x, lin_y, lin_z;
      logic signed [31:0] ang_x, ang_y, ang_z;
   } row_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] vec_x, vec_y, vec_z;
      logic signed [31:0] aux_x, aux_y, aux_z;
      logic signed [31:0] quat_w;
   } request_type;

   // stored contact, cleared at reset
   longint normal_q [3];
   longint point_q [3];
   row_type expected_rows [$];

   function automatic longint clip(longint a);
      if (a > SAT_HI) return SAT_HI;
      if (a < SAT_LO) return SAT_LO;
      return a;
   endfunction

   function automatic longint q_add(longint a, longint b);
      return clip(a + b);
   endfunction

   function automatic longint q_sub(longint a, longint b);
      return clip(a - b);
   endfunction

   // exact product, floor shift by the fraction bits
   function automatic longint q_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clip(p >>> 16);
   endfunction

   function automatic longint q_dbl(longint a);
      return clip(a + a);
   endfunction

   function automatic row_type jacobian_row(request_type r);
      longint u [3];
      longint w, s, cx, cy, cz, ex, ey, ez, a, l;
      longint d [3];
      longint m [3][3];
      row_type row;
      u[0] = r.aux_x; u[1] = r.aux_y; u[2] = r.aux_z; w = r.quat_w;
      s = q_sub(q_mul(w, w), q_add(q_add(q_mul(u[0], u[0]), q_mul(u[1], u[1])),
                                   q_mul(u[2], u[2])));
      for (int i = 0; i < 3; i++) m[i][i] = q_add(s, q_dbl(q_mul(u[i], u[i])));
      m[0][1] = q_sub(q_dbl(q_mul(u[0], u[1])), q_dbl(q_mul(w, u[2])));
      m[0][2] = q_add(q_dbl(q_mul(u[0], u[2])), q_dbl(q_mul(w, u[1])));
      m[1][0] = q_add(q_dbl(q_mul(u[1], u[0])), q_dbl(q_mul(w, u[2])));
      m[1][2] = q_sub(q_dbl(q_mul(u[1], u[2])), q_dbl(q_mul(w, u[0])));
      m[2][0] = q_sub(q_dbl(q_mul(u[2], u[0])), q_dbl(q_mul(w, u[1])));
      m[2][1] = q_add(q_dbl(q_mul(u[2], u[1])), q_dbl(q_mul(w, u[0])));
      d[0] = q_sub(r.vec_x, point_q[0]);
      d[1] = q_sub(r.vec_y, point_q[1]);
      d[2] = q_sub(r.vec_z, point_q[2]);
      row.body_index = (r.action == ACT_BODY1);
      for (int j = 0; j < 3; j++) begin
         cx = m[0][j]; cy = m[1][j]; cz = m[2][j];
         ex = q_sub(q_mul(d[1], cz), q_mul(d[2], cy));
         ey = q_sub(q_mul(d[2], cx), q_mul(d[0], cz));
         ez = q_sub(q_mul(d[0], cy), q_mul(d[1], cx));
         a = q_add(q_add(q_mul(normal_q[0], ex), q_mul(normal_q[1], ey)),
                   q_mul(normal_q[2], ez));
         l = normal_q[j];
         // second body negates, saturating at the most negative value
         if (row.body_index) begin
            a = clip(-a);
            l = clip(-l);
         end
         case (j)
            0: begin row.lin_x = l[31:0]; row.ang_x = a[31:0]; end
            1: begin row.lin_y = l[31:0]; row.ang_y = a[31:0]; end
            default: begin row.lin_z = l[31:0]; row.ang_z = a[31:0]; end
         endcase
      end
      return row;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      request_type r;
      row_type got, want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            normal_q[k] = 0;
            point_q[k] = 0;
         end
         expected_rows.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (expected_rows.size() == 0) begin
               $display("unexpected response %h at %0t", rsp.data, $realtime);
               fail_count++;
            end else begin
               want = expected_rows.pop_front();
               if (got.body_index != want.body_index)
                  report_mismatch("body_index", got.body_index, want.body_index);
               if (got.lin_x != want.lin_x) report_mismatch("lin_x", got.lin_x, want.lin_x);
               if (got.lin_y != want.lin_y) report_mismatch("lin_y", got.lin_y, want.lin_y);
               if (got.lin_z != want.lin_z) report_mismatch("lin_z", got.lin_z, want.lin_z);
               if (got.ang_x != want.ang_x) report_mismatch("ang_x", got.ang_x, want.ang_x);
               if (got.ang_y != want.ang_y) report_mismatch("ang_y", got.ang_y, want.ang_y);
               if (got.ang_z != want.ang_z) report_mismatch("ang_z", got.ang_z, want.ang_z);
            end
         end
         if (req.valid && req.ready) begin
            r = req.data;
            if (r.action == ACT_CONTACT) begin
               normal_q[0] = r.vec_x; normal_q[1] = r.vec_y; normal_q[2] = r.vec_z;
               point_q[0] = r.aux_x; point_q[1] = r.aux_y; point_q[2] = r.aux_z;
            end else if (r.action == ACT_BODY0 || r.action == ACT_BODY1) begin
               expected_rows.push_back(jacobian_row(r));
            end
         end
      end
      rows_pending = expected_rows.size();
   end

endmodule

[tb/testbench.sv]
// stimulus and verdict for the contact jacobian row unit
`timescale 1ns / 1ps
module testbench;
   import cjr_pkg::*;

   localparam int REQ_WIDTH = 2 + 7 * 32;
   localparam int RSP_WIDTH = 1 + 6 * 32;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [31:0] Q_MAX = 32'h7fffffff;
   localparam logic [31:0] Q_MIN = 32'h80000000;
   localparam logic [31:0] Q_ONE = 32'h00010000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int rows_pending;
   int stall_left = 0;

   cjr_if #(.PAYLOAD_WIDTH(REQ_WIDTH)) req_ch ();
   cjr_if #(.PAYLOAD_WIDTH(RSP_WIDTH)) rsp_ch ();

   contact_jacobian_row_rotated_frame_unit uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   cjr_row_checker row_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .fail_count(fail_count), .rows_pending(rows_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // response side back-pressure, with runs of no stalling
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) < 3) stall_left <= gap_len();
      end
   end

   // random q16.16 value: mostly moderate, some full range and extremes
   function automatic logic [31:0] rand_q();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return $urandom_range(0, 32'h0007ffff) - 32'h00040000;
      if (p < 85) return $urandom();
      if (p < 90) return Q_MAX;
      if (p < 95) return Q_MIN;
      return $urandom_range(0, 2) - 1;
   endfunction

   // near-unit quaternion part, occasionally wild
   function automatic logic [31:0] rand_quat();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 32'h0001ffff) - Q_ONE;
      return rand_q();
   endfunction

   // send one request, then a random idle gap, possibly none
   task automatic send_request(logic [1:0] action, logic [31:0] vx, logic [31:0] vy,
                               logic [31:0] vz, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] az, logic [31:0] qw);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.data <= {action, vx, vy, vz, ax, ay, az, qw};
      do @(posedge clock); while (!req_ch.ready);
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_body(logic [1:0] action);
      send_request(action, rand_q(), rand_q(), rand_q(),
                   rand_quat(), rand_quat(), rand_quat(), rand_quat());
   endtask

   initial begin
      int sent;
      int guard;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: body before any contact, unused action, extremes
      send_request(ACT_BODY0, Q_ONE, Q_MAX, Q_MIN, 0, 0, 0, Q_ONE);
      send_request(ACT_UNUSED, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_request(ACT_BODY1, Q_ONE, 0, 0, 0, 0, 0, Q_ONE);
      send_request(ACT_CONTACT, Q_ONE, 0, 0, 0, 0, 0, Q_MAX);
      send_request(ACT_BODY0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE);
      send_request(ACT_BODY1, 0, 0, Q_ONE, Q_ONE, 0, 0, 0);
      send_request(ACT_BODY0, Q_ONE, Q_ONE, 0, 32'h0000b505, 0, 0, 32'h0000b505);
      send_request(ACT_CONTACT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
      send_request(ACT_BODY1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      send_request(ACT_BODY0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      send_request(ACT_UNUSED, 0, 0, 0, 0, 0, 0, 0);
      send_request(ACT_BODY1, 0, 0, 0, 32'h00020000, 32'h00030000, 0, 32'h00020000);
      send_request(ACT_CONTACT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0);
      send_request(ACT_BODY1, Q_MAX, Q_MIN, 32'hffffffff, 32'hffffffff, 1, Q_MAX, Q_MIN);
      send_request(ACT_BODY0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

      // random: mostly a contact followed by both bodies, some noise
      sent = 0;
      while (sent < 600) begin
         if ($urandom_range(0, 9) < 8) begin
            send_request(ACT_CONTACT, rand_q(), rand_q(), rand_q(),
                         rand_q(), rand_q(), rand_q(), $urandom());
            send_body(ACT_BODY0);
            send_body(ACT_BODY1);
            sent += 3;
         end else begin
            send_request(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom());
            sent++;
         end
         // let the unit drain completely midway, at least once
         if (sent >= 300 && sent < 304) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (rows_pending != 0);
         end
      end
      req_ch.valid <= 1'b0;

      guard = 0;
      while (rows_pending != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && rows_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
